// ----- rtl/prq_pkg.sv -----
// package for the priority run queue: sizes, codes, payload and link types
// used by prq_ctrl, prq_datapath and priority_run_queue_unit; no dependencies
package prq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PRIO_W      = 8;
  localparam int TASK_W      = 6;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 7;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic              action;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
  } prq_in_t;

  typedef struct packed {
    logic [TASK_W-1:0]   popped_task;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } prq_out_t;

  // command from controller to datapath
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
  } prq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic              full;
    logic              empty;
    logic [TASK_W-1:0] head_task;
  } prq_stat_t;

endpackage

// ----- rtl/prq_datapath.sv -----
// sorted cell chain of queued tasks with the entry count
// depends on prq_pkg; driven by prq_ctrl through prq_cmd_t
module prq_datapath
  import prq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  prq_cmd_t  cmd,
  output prq_stat_t stat
);

  logic [TASK_W-1:0] slot_task [QUEUE_DEPTH];
  logic [PRIO_W-1:0] slot_prio [QUEUE_DEPTH];
  logic [TASK_W-1:0] slot_task_next [QUEUE_DEPTH];
  logic [PRIO_W-1:0] slot_prio_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // each cell holds when it is valid and ranks at or above the new task
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < count) && (slot_prio[i] >= cmd.prio);
    end
  end

  // per-cell next value: hold, take the new task, or shift along the chain
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_task_next[i] = slot_task[i];
      slot_prio_next[i] = slot_prio[i];
    end
    if (cmd.push) begin
      if (!keep[0]) begin
        slot_task_next[0] = cmd.task_id;
        slot_prio_next[0] = cmd.prio;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (!keep[i]) begin
          if (keep[i-1]) begin
            slot_task_next[i] = cmd.task_id;
            slot_prio_next[i] = cmd.prio;
          end else begin
            slot_task_next[i] = slot_task[i-1];
            slot_prio_next[i] = slot_prio[i-1];
          end
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        slot_task_next[i] = slot_task[i+1];
        slot_prio_next[i] = slot_prio[i+1];
      end
    end
  end

  // entry count update
  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  // cell registers, payload only
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_task[i] <= slot_task_next[i];
      slot_prio[i] <= slot_prio_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign stat.count     = count;
  assign stat.full      = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.head_task = slot_task[0];

endmodule

// ----- rtl/prq_ctrl.sv -----
// controller: takes one request, issues push or pop, forms the result
// depends on prq_pkg; commands prq_datapath
module prq_ctrl
  import prq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  prq_in_t   item,
  output logic      busy,
  output logic      done,
  output prq_out_t  result,
  output prq_cmd_t  cmd,
  input  prq_stat_t stat
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t  state;
  prq_in_t req;
  logic    do_push;
  logic    do_pop;
  logic [CNT_W-1:0] count_after;

  // decode the held request against the queue status
  always_comb begin
    do_push = (state == ST_EXEC) && (req.action == ACT_PUSH) && !stat.full;
    do_pop  = (state == ST_EXEC) && (req.action == ACT_POP) && !stat.empty;
    count_after = stat.count;
    if (do_push) begin
      count_after = stat.count + CNT_W'(1);
    end else if (do_pop) begin
      count_after = stat.count - CNT_W'(1);
    end
  end

  assign cmd.push    = do_push;
  assign cmd.pop     = do_pop;
  assign cmd.task_id = req.task_id;
  assign cmd.prio    = req.priority_req;

  // state, request latch and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start && !busy) begin
            req   <= item;
            busy  <= 1'b1;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done                <= 1'b1;
          busy                <= 1'b0;
          state               <= ST_IDLE;
          result.occupancy    <= OCC_W'(count_after);
          result.popped_task  <= '0;
          result.status       <= STATUS_OK;
          if (req.action == ACT_PUSH) begin
            if (stat.full) begin
              result.status <= STATUS_FULL;
            end
          end else if (stat.empty) begin
            result.status <= STATUS_EMPTY;
          end else begin
            result.popped_task <= stat.head_task;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/priority_run_queue_unit.sv -----
// top level of the priority run queue: controller plus sorted cell chain
// depends on prq_pkg, prq_ctrl and prq_datapath
//
// usage:
//   a request transfer happens on a rising edge with start high and busy low.
//   item.action selects push (task_id, priority_req) or pop of the head task.
//   a push goes behind every queued task of equal or higher priority.
//   busy rises for one cycle after each transfer while the cell chain updates.
//   the result is on result for exactly one cycle with done high, registered as
//   the execute state that follows the request edge ends;
//   the receiver cannot hold it off.
//   a new request is taken only after the last one is through: the request
//   is latched, then the chain updates with all cells compared in parallel.
//   a pop of an empty queue returns task 0 with status empty; a push into a
//   full queue is dropped and returns status full.
//   occupancy is the number of queued tasks after the request.
//   synchronous reset empties the queue and drops any request in progress;
//   no clearing pass is needed.
module priority_run_queue_unit
  import prq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  prq_in_t  item,
  output logic     busy,
  output logic     done,
  output prq_out_t result
);

  prq_cmd_t  cmd;
  prq_stat_t stat;

  prq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result),
    .cmd    (cmd),
    .stat   (stat)
  );

  prq_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

// ----- bench/tb_priority_run_queue_unit.sv -----
// testbench for priority_run_queue_unit: random bursts of push and pop transfers
// checked against a sorted-list model of the run queue; depends on prq_pkg and priority_run_queue_unit
`timescale 1ns / 1ps

module tb_priority_run_queue_unit;
  import prq_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    prq_in_t req;
    bit      drain_first;
  } sched_req_t;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  prq_in_t  item  = '0;
  logic     busy;
  logic     done;
  prq_out_t result;

  priority_run_queue_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sched_req_t        pending_reqs[$];
  prq_out_t          expected_results[$];
  int                issued_count = 0;
  int                results_seen = 0;
  int                error_count  = 0;
  int                cycle_count  = 0;
  int                burst_left   = 0;
  int                gap_left     = 0;

  // shadow copy of the run queue, slot 0 is the head
  logic [TASK_W-1:0] shadow_task[QUEUE_DEPTH];
  logic [PRIO_W-1:0] shadow_prio[QUEUE_DEPTH];
  int                shadow_count = 0;

  // apply one request to the shadow queue and return the expected result
  function automatic prq_out_t run_queue_step(prq_in_t req);
    prq_out_t res;
    int       pos;
    int       i;
    res.popped_task = '0;
    res.status      = STATUS_OK;
    if (req.action == ACT_PUSH) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        // insert behind every entry of equal or higher priority
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= req.priority_req) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_task[i] = shadow_task[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_task[pos] = req.task_id;
        shadow_prio[pos] = req.priority_req;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.popped_task = shadow_task[0];
      for (i = 1; i < shadow_count; i++) begin
        shadow_task[i-1] = shadow_task[i];
        shadow_prio[i-1] = shadow_prio[i];
      end
      shadow_count--;
    end
    res.occupancy = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  task automatic add_request(logic act, logic [TASK_W-1:0] tid, logic [PRIO_W-1:0] pr,
                             bit drain);
    sched_req_t r;
    r.req.action       = act;
    r.req.task_id      = tid;
    r.req.priority_req = pr;
    r.drain_first      = drain;
    pending_reqs.push_back(r);
  endtask

  // clustered priorities so that ties are common
  function automatic logic [PRIO_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return PRIO_W'($urandom_range(0, 3));
      1:       return PRIO_W'($urandom);
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return PRIO_W'($urandom_range(120, 130));
    endcase
  endfunction

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    prq_out_t   want;
    logic       next_start;
    int         issued_now;
    sched_req_t next_req;
    if (rst) begin
      start <= 1'b0;
    end else begin
      issued_now = issued_count;
      if (start && !busy) begin
        want = run_queue_step(item);
        expected_results.push_back(want);
        issued_now   = issued_count + 1;
        issued_count <= issued_now;
      end
      if (!start || !busy) begin
        next_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain_first || issued_now == results_seen)) begin
          next_req   = pending_reqs.pop_front();
          item       <= next_req.req;
          next_start = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        start <= next_start;
      end
    end
  end

  // monitor: every done strobe carries one result, matched against the oldest expectation
  always @(posedge clk) begin
    prq_out_t want;
    if (!rst && done) begin
      if (issued_count == results_seen) begin
        $error("unexpected result: task %0d status %0d occupancy %0d",
               result.popped_task, result.status, result.occupancy);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_seen <= results_seen + 1;
        if (result.popped_task !== want.popped_task) begin
          $error("popped_task: expected %0d, actual %0d", want.popped_task, result.popped_task);
          error_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result.status);
          error_count++;
        end
        if (result.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, result.occupancy);
          error_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int  random_done;
    int  phase_len;
    int  push_pct;
    int  n;
    bit  drain;

    // directed: empty pop, priority extremes, ties in arrival order
    add_request(ACT_POP,  6'd17, 8'd200, 1'b0);
    add_request(ACT_PUSH, 6'd63, 8'd0,   1'b0);
    add_request(ACT_PUSH, 6'd0,  8'd255, 1'b0);
    add_request(ACT_PUSH, 6'd5,  8'd255, 1'b0);
    add_request(ACT_PUSH, 6'd7,  8'd0,   1'b0);
    add_request(ACT_PUSH, 6'd9,  8'd128, 1'b0);
    add_request(ACT_PUSH, 6'd42, 8'd128, 1'b0);
    add_request(ACT_POP,  6'd63, 8'd255, 1'b0);
    add_request(ACT_POP,  6'd0,  8'd0,   1'b0);
    add_request(ACT_POP,  6'd0,  8'd0,   1'b0);
    add_request(ACT_POP,  6'd0,  8'd0,   1'b0);
    add_request(ACT_POP,  6'd0,  8'd0,   1'b0);
    add_request(ACT_POP,  6'd0,  8'd0,   1'b0);
    add_request(ACT_POP,  6'd0,  8'd0,   1'b0);
    add_request(ACT_PUSH, 6'd63, 8'd255, 1'b0);
    add_request(ACT_PUSH, 6'd21, 8'd170, 1'b0);
    add_request(ACT_PUSH, 6'd42, 8'd85,  1'b0);
    add_request(ACT_POP,  6'd63, 8'd255, 1'b0);
    add_request(ACT_POP,  6'd0,  8'd0,   1'b0);
    add_request(ACT_POP,  6'd0,  8'd0,   1'b0);
    add_request(ACT_POP,  6'd0,  8'd0,   1'b0);

    // random phases: fill past full, drain past empty, mixed traffic
    random_done = 0;
    push_pct    = 100;
    phase_len   = 70;
    while (random_done < RANDOM_ITEMS) begin
      drain = (random_done == 0) || ($urandom_range(0, 2) == 0);
      for (n = 0; n < phase_len; n++) begin
        add_request(($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP,
                    TASK_W'($urandom_range(0, 63)), pick_priority(), drain);
        drain = 1'b0;
      end
      random_done += phase_len;
      case ($urandom_range(0, 2))
        0: begin
          push_pct  = 90;
          phase_len = $urandom_range(80, 120);
        end
        1: begin
          push_pct  = 10;
          phase_len = $urandom_range(80, 120);
        end
        default: begin
          push_pct  = 50;
          phase_len = $urandom_range(30, 80);
        end
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // wait for the last transfer, then for every result, then a short settle
    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (results_seen != issued_count) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
